### rtl/bclru_pkg.sv
// Shared types and codes of the LRU block-buffer cache directory.
// No dependencies.
`default_nettype none
package bclru_pkg;
    localparam int SLOTS  = 16;
    localparam int SLOT_W = 4;
    localparam int RANK_W = 4;
    localparam int CNT_W  = 5;
    localparam int BLK_W  = 32;
    localparam int BYT_W  = 17;
    localparam int RC_W   = 8;

    localparam logic [CNT_W-1:0] MAXBUF_RESET = 5'd10;
    localparam logic [RC_W-1:0]  RC_MAX       = 8'd255;

    localparam logic [1:0] REQ_GET     = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_FILL    = 2'd2;
    localparam logic [1:0] REQ_NONE    = 2'd3;

    localparam logic [3:0] ST_HIT    = 4'd0;
    localparam logic [3:0] ST_NEW    = 4'd1;
    localparam logic [3:0] ST_REUSED = 4'd2;
    localparam logic [3:0] ST_NOSLOT = 4'd3;
    localparam logic [3:0] ST_KEPT   = 4'd4;
    localparam logic [3:0] ST_FREED  = 4'd5;
    localparam logic [3:0] ST_HELD   = 4'd6;
    localparam logic [3:0] ST_FILLED = 4'd7;
    localparam logic [3:0] ST_BAD    = 4'd8;

    typedef struct packed {
        logic capture;
        logic eval;
        logic commit;
    } t_ctrl_cmd;
endpackage
`default_nettype wire

### rtl/bclru_ctrl.sv
// Sequencer of the cache directory: capture, compare, commit.
// Depends on bclru_pkg.
`default_nettype none
module bclru_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_tvalid,
    input  wire                 i_out_tready,
    output logic                o_in_tready,
    output logic                o_out_tvalid,
    output bclru_pkg::t_ctrl_cmd o_cmd
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EVAL   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       out_free;

    assign out_free     = !r_ovalid || i_out_tready;
    // Hold off requests while reset is applied.
    assign o_in_tready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_tvalid = r_ovalid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_ovalid = o_cmd.commit ? 1'b1 : (i_out_tready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end
endmodule
`default_nettype wire

### rtl/bclru_dp.sv
// Datapath of the cache directory: slot table, tag compare, LRU pick, result register.
// Depends on bclru_pkg.
`default_nettype none
module bclru_dp (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  bclru_pkg::t_ctrl_cmd            i_cmd,
    input  wire                             i_cfg_we,
    input  wire  [bclru_pkg::CNT_W-1:0]     i_cfg_wdata,
    input  wire  [1:0]                      i_req,
    input  wire  [bclru_pkg::BLK_W-1:0]     i_blk,
    input  wire  [bclru_pkg::BYT_W-1:0]     i_bytes,
    input  wire  [bclru_pkg::SLOT_W-1:0]    i_si,
    input  wire                             i_dirty,
    output logic [3:0]                      o_status,
    output logic [bclru_pkg::SLOT_W-1:0]    o_slot,
    output logic                            o_fill,
    output logic                            o_wb,
    output logic [bclru_pkg::BLK_W-1:0]     o_wbb,
    output logic [bclru_pkg::CNT_W-1:0]     o_count
);
    localparam int N = bclru_pkg::SLOTS;

    logic [bclru_pkg::CNT_W-1:0] r_max;
    logic [1:0]                  r_req;
    logic [bclru_pkg::BLK_W-1:0] r_blk;
    logic [bclru_pkg::BYT_W-1:0] r_bytes;
    logic [bclru_pkg::SLOT_W-1:0] r_si;
    logic                        r_dirty;

    logic [N-1:0] r_used, n_used, r_valid, n_valid;
    logic [bclru_pkg::RC_W-1:0]   r_rc   [N], n_rc   [N];
    logic [bclru_pkg::RANK_W-1:0] r_rank [N], n_rank [N];
    logic [bclru_pkg::BLK_W-1:0]  r_sblk [N], n_sblk [N];
    logic [bclru_pkg::BYT_W-1:0]  r_sbyt [N], n_sbyt [N];
    logic [bclru_pkg::CNT_W-1:0]  r_cnt, n_cnt;

    logic [N-1:0] r_match, r_cand, win;

    logic [3:0]                   n_status;
    logic [bclru_pkg::SLOT_W-1:0] n_slot;
    logic                         n_fill, n_wb;
    logic [bclru_pkg::BLK_W-1:0]  n_wbb;

    always_comb begin
        logic [bclru_pkg::SLOT_W-1:0] h, fr, lr, s;
        logic                          hit_any, free_any, lru_any, to_hd, dec_rk;
        logic [bclru_pkg::RANK_W-1:0]  rk;
        logic [bclru_pkg::RC_W-1:0]    rc_dec;
        h = '0; fr = '0; lr = '0; s = '0;
        hit_any = |r_match;
        free_any = ~&r_used;
        lru_any = |r_cand;
        to_hd = 1'b0; dec_rk = 1'b0;
        rc_dec = '0;
        for (int i = 0; i < N; i++) begin
            win[i] = r_cand[i];
            for (int j = 0; j < N; j++)
                if (j != i && r_cand[j] && r_rank[j] >= r_rank[i]) win[i] = 1'b0;
        end
        for (int i = 0; i < N; i++) begin
            if (r_match[i]) h  = bclru_pkg::SLOT_W'(i);
            if (win[i])     lr = bclru_pkg::SLOT_W'(i);
        end
        for (int i = N - 1; i >= 0; i--)
            if (!r_used[i]) fr = bclru_pkg::SLOT_W'(i);

        n_used = r_used; n_valid = r_valid; n_cnt = r_cnt;
        n_rc = r_rc; n_rank = r_rank; n_sblk = r_sblk; n_sbyt = r_sbyt;
        n_status = bclru_pkg::ST_BAD; n_slot = r_si;
        n_fill = 1'b0; n_wb = 1'b0; n_wbb = '0;

        if (r_req == bclru_pkg::REQ_GET) begin
            n_slot = '0;
            if (hit_any) begin
                s = h; to_hd = 1'b1;
                if (r_rc[h] != bclru_pkg::RC_MAX) n_rc[h] = r_rc[h] + 1'b1;
                n_status = bclru_pkg::ST_HIT; n_slot = h; n_fill = !r_valid[h];
            end else if ((r_cnt < r_max || !lru_any) && free_any) begin
                for (int i = 0; i < N; i++)
                    if (r_used[i]) n_rank[i] = r_rank[i] + 1'b1;
                n_used[fr] = 1'b1; n_rank[fr] = '0; n_cnt = r_cnt + 1'b1;
                n_sblk[fr] = r_blk; n_sbyt[fr] = r_bytes;
                n_valid[fr] = 1'b0; n_rc[fr] = 8'd1;
                n_status = bclru_pkg::ST_NEW; n_slot = fr; n_fill = 1'b1;
            end else if (!lru_any) begin
                n_status = bclru_pkg::ST_NOSLOT;
            end else begin
                s = lr; to_hd = 1'b1;
                n_sblk[lr] = r_blk; n_valid[lr] = 1'b0; n_rc[lr] = 8'd1;
                n_status = bclru_pkg::ST_REUSED; n_slot = lr; n_fill = 1'b1;
            end
        end else if (r_req != bclru_pkg::REQ_NONE && r_used[r_si]) begin
            if (r_req == bclru_pkg::REQ_FILL) begin
                n_valid[r_si] = 1'b1;
                n_status = bclru_pkg::ST_FILLED;
            end else begin
                rc_dec = (r_rc[r_si] != '0) ? r_rc[r_si] - 1'b1 : '0;
                n_rc[r_si] = rc_dec;
                n_wb  = r_dirty;
                n_wbb = r_dirty ? r_sblk[r_si] : '0;
                if (rc_dec != '0) begin
                    n_status = bclru_pkg::ST_HELD;
                end else if (r_cnt > r_max) begin
                    s = r_si; dec_rk = 1'b1;
                    n_used[r_si] = 1'b0; n_valid[r_si] = 1'b0;
                    n_cnt = r_cnt - 1'b1;
                    n_status = bclru_pkg::ST_FREED;
                end else begin
                    n_status = bclru_pkg::ST_KEPT;
                end
            end
        end

        rk = r_rank[s];
        if (to_hd || dec_rk) begin
            // Shift neighbors of the moved slot by one rank.
            for (int i = 0; i < N; i++) begin
                if (r_used[i] && i != int'(s)) begin
                    if (to_hd && r_rank[i] < rk) n_rank[i] = r_rank[i] + 1'b1;
                    if (dec_rk && r_rank[i] > rk) n_rank[i] = r_rank[i] - 1'b1;
                end
            end
            n_rank[s] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= bclru_pkg::MAXBUF_RESET;
            r_used  <= '0;
            r_valid <= '0;
            r_cnt   <= '0;
            for (int i = 0; i < N; i++) r_rc[i] <= '0;
        end else begin
            if (i_cfg_we) r_max <= i_cfg_wdata;
            if (i_cmd.commit) begin
                r_used  <= n_used;
                r_valid <= n_valid;
                r_cnt   <= n_cnt;
                r_rc    <= n_rc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req; r_blk <= i_blk; r_bytes <= i_bytes;
            r_si <= i_si; r_dirty <= i_dirty;
        end
        if (i_cmd.eval) begin
            for (int i = 0; i < N; i++) begin
                r_match[i] <= r_used[i] && r_sbyt[i] == r_bytes && r_sblk[i] == r_blk;
                r_cand[i]  <= r_used[i] && r_sbyt[i] == r_bytes && r_rc[i] == '0;
            end
        end
        if (i_cmd.commit) begin
            r_rank <= n_rank; r_sblk <= n_sblk; r_sbyt <= n_sbyt;
            o_status <= n_status; o_slot <= n_slot; o_fill <= n_fill;
            o_wb <= n_wb; o_wbb <= n_wbb; o_count <= n_cnt;
        end
    end
endmodule
`default_nettype wire

### rtl/buffer_cache_lru_refcount_top.sv
// Top level of the LRU block-buffer cache directory with reference counts.
// Depends on bclru_pkg, bclru_ctrl and bclru_dp.
`default_nettype none
// Each request passes the capture, eval and commit steps in turn: capture registers
// it, eval latches the parallel tag compare over all sixteen slots, and commit picks
// the hit, free or least recently used slot, updates the table and loads the
// result register. The table itself is the limit: one request is worked at a time,
// so a new request is accepted only after the last one has been committed.
// A finished result sits in an output register, and the next request is
// accepted while it waits; a stalled result holds the commit of the next one.
module buffer_cache_lru_refcount_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire  [4:0]  i_cfg_wdata,   // max_buffers
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [55:0] s_axis_tdata,  // block_number, block_bytes, slot_index, dirty_flag
    input  wire  [1:0]  s_axis_tuser,  // req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,  // slot, needs_fill, writeback, writeback_block,
                                       // buffers_in_use
    output logic [3:0]  m_axis_tuser   // status
);
    bclru_pkg::t_ctrl_cmd cmd;
    logic [3:0]  slot;
    logic        fill, wb;
    logic [31:0] wbb;
    logic [4:0]  cnt;

    bclru_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_tvalid  (s_axis_tvalid),
        .i_out_tready (m_axis_tready),
        .o_in_tready  (s_axis_tready),
        .o_out_tvalid (m_axis_tvalid),
        .o_cmd        (cmd)
    );

    bclru_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (s_axis_tuser),
        .i_blk       (s_axis_tdata[31:0]),
        .i_bytes     (s_axis_tdata[48:32]),
        .i_si        (s_axis_tdata[52:49]),
        .i_dirty     (s_axis_tdata[53]),
        .o_status    (m_axis_tuser),
        .o_slot      (slot),
        .o_fill      (fill),
        .o_wb        (wb),
        .o_wbb       (wbb),
        .o_count     (cnt)
    );

    // Pack the result fields, lowest first, padded to whole bytes.
    assign m_axis_tdata = {5'd0, cnt, wbb, wb, fill, slot};
endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for buffer_cache_lru_refcount_top: directed and random cache requests.
// A local copy of the directory table predicts every response. Depends on bclru_pkg.
module tb_top;
    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic        fill;
        logic        wb;
        logic [31:0] wb_blk;
        logic [4:0]  in_use;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;   // block_number, block_bytes, slot_index, dirty_flag
    logic [1:0]  s_axis_tuser = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // slot, needs_fill, writeback, writeback_block,
                                      // buffers_in_use
    logic [3:0]  m_axis_tuser;        // status

    buffer_cache_lru_refcount_top dut (.*);

    initial forever #5 i_clk = ~i_clk;

    // Local directory table, mirrors the block's state.
    logic [4:0]  lim;
    logic        used  [bclru_pkg::SLOTS];
    logic [31:0] blkno [bclru_pkg::SLOTS];
    logic [16:0] bsize [bclru_pkg::SLOTS];
    logic [7:0]  refs  [bclru_pkg::SLOTS];
    logic        valid [bclru_pkg::SLOTS];
    logic [3:0]  rank  [bclru_pkg::SLOTS];
    logic [4:0]  nbuf;

    t_resp pending[$];
    int    errors = 0;
    bit    burst = 0;      // no idling on either side while set
    bit    held_high = 0;  // request valid left high after the last acceptance

    function automatic t_resp mk(logic [3:0] st, logic [3:0] s, logic f, logic w,
                                 logic [31:0] wbb);
        t_resp r;
        r.status = st; r.slot = s; r.fill = f; r.wb = w;
        r.wb_blk = w ? wbb : 32'd0; r.in_use = nbuf;
        return r;
    endfunction

    function automatic void move_to_head(int s);
        logic [3:0] r;
        r = rank[s];
        for (int i = 0; i < bclru_pkg::SLOTS; i++)
            if (used[i] && i != s && rank[i] < r) rank[i]++;
        rank[s] = 4'd0;
    endfunction

    // Work out the response to one request and update the table.
    function automatic t_resp lookup_update(logic [1:0] req, logic [31:0] blk,
                                            logic [16:0] bytes, logic [3:0] si, logic dirty);
        int hit, lru, fr, s;
        logic [31:0] wbb;
        hit = -1; lru = -1; fr = -1;
        if (req == bclru_pkg::REQ_GET) begin
            for (int i = 0; i < bclru_pkg::SLOTS; i++) begin
                if (!used[i]) begin
                    if (fr < 0) fr = i;
                end else if (bsize[i] == bytes) begin
                    if (blkno[i] == blk && (hit < 0 || rank[i] < rank[hit])) hit = i;
                    if (refs[i] == 0 && (lru < 0 || rank[i] > rank[lru])) lru = i;
                end
            end
            if (hit >= 0) begin
                move_to_head(hit);
                if (refs[hit] != bclru_pkg::RC_MAX) refs[hit]++;
                return mk(bclru_pkg::ST_HIT, 4'(hit), !valid[hit], 1'b0, 32'd0);
            end
            if ((nbuf < lim || lru < 0) && fr >= 0) begin
                for (int i = 0; i < bclru_pkg::SLOTS; i++) if (used[i]) rank[i]++;
                used[fr] = 1'b1; rank[fr] = 4'd0; nbuf++;
                blkno[fr] = blk; bsize[fr] = bytes; valid[fr] = 1'b0; refs[fr] = 8'd1;
                return mk(bclru_pkg::ST_NEW, 4'(fr), 1'b1, 1'b0, 32'd0);
            end
            if (lru < 0) return mk(bclru_pkg::ST_NOSLOT, 4'd0, 1'b0, 1'b0, 32'd0);
            move_to_head(lru);
            blkno[lru] = blk; valid[lru] = 1'b0; refs[lru] = 8'd1;
            return mk(bclru_pkg::ST_REUSED, 4'(lru), 1'b1, 1'b0, 32'd0);
        end
        if (req == bclru_pkg::REQ_NONE || !used[si])
            return mk(bclru_pkg::ST_BAD, si, 1'b0, 1'b0, 32'd0);
        if (req == bclru_pkg::REQ_FILL) begin
            valid[si] = 1'b1;
            return mk(bclru_pkg::ST_FILLED, si, 1'b0, 1'b0, 32'd0);
        end
        wbb = blkno[si];
        if (refs[si] > 0) refs[si]--;
        if (refs[si] > 0) return mk(bclru_pkg::ST_HELD, si, 1'b0, dirty, wbb);
        if (nbuf > lim) begin
            for (int i = 0; i < bclru_pkg::SLOTS; i++)
                if (used[i] && i != si && rank[i] > rank[si]) rank[i]--;
            used[si] = 1'b0; valid[si] = 1'b0; rank[si] = 4'd0; nbuf--;
            return mk(bclru_pkg::ST_FREED, si, 1'b0, dirty, wbb);
        end
        return mk(bclru_pkg::ST_KEPT, si, 1'b0, dirty, wbb);
    endfunction

    function automatic int gap_draw();
        return burst ? 0 : int'($urandom_range(18, 0));
    endfunction

    // Send one request; predict it once accepted. Leave valid high if no gap follows.
    task automatic send(logic [1:0] req, logic [31:0] blk, logic [16:0] bytes,
                        logic [3:0] si, logic dirty);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {2'b00, dirty, si, bytes, blk};
        do @(posedge i_clk); while (!s_axis_tready);
        pending.push_back(lookup_update(req, blk, bytes, si, dirty));
        gap = gap_draw();
        held_high = (gap == 0);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid, wait for every response, then let the pipeline settle.
    task automatic drain();
        if (held_high) begin
            s_axis_tvalid <= 1'b0;
            held_high = 0;
        end
        while (pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_limit(logic [4:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim = v;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    // Response side: random stall per response, checked against the oldest prediction.
    int stall = 0;
    always @(posedge i_clk) begin
        t_resp w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending.size() == 0) begin
                report("unexpected response", 32'(m_axis_tuser), 32'd0);
            end else begin
                w = pending.pop_front();
                if (m_axis_tuser != w.status)
                    report("status", 32'(m_axis_tuser), 32'(w.status));
                if (m_axis_tdata[3:0] != w.slot)
                    report("slot", 32'(m_axis_tdata[3:0]), 32'(w.slot));
                if (m_axis_tdata[4] != w.fill)
                    report("needs_fill", 32'(m_axis_tdata[4]), 32'(w.fill));
                if (m_axis_tdata[5] != w.wb)
                    report("writeback", 32'(m_axis_tdata[5]), 32'(w.wb));
                if (m_axis_tdata[37:6] != w.wb_blk)
                    report("wb_block", m_axis_tdata[37:6], w.wb_blk);
                if (m_axis_tdata[42:38] != w.in_use)
                    report("in_use", 32'(m_axis_tdata[42:38]), 32'(w.in_use));
            end
            stall = gap_draw();
        end
        if (stall > 0) begin
            m_axis_tready <= 1'b0;
            stall--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [16:0] pick_bytes();
        int k;
        k = $urandom_range(19, 0);
        if (k == 0) return 17'd1;
        if (k == 1) return 17'd65536;
        if (k == 2) return 17'($urandom_range(65536, 1));
        return (k < 10) ? 17'd4096 : (k < 15 ? 17'd1024 : 17'd512);
    endfunction

    function automatic logic [31:0] pick_block();
        int k;
        k = $urandom_range(19, 0);
        if (k == 0) return 32'hFFFF_FFFF;
        if (k < 3) return $urandom;
        return $urandom_range(23, 0);
    endfunction

    // Pick a slot: mostly an allocated one, sometimes any index.
    function automatic logic [3:0] pick_slot();
        int s;
        s = $urandom_range(bclru_pkg::SLOTS - 1, 0);
        if ($urandom_range(9, 0) < 8)
            for (int i = 0; i < bclru_pkg::SLOTS; i++)
                if (used[(s + i) % bclru_pkg::SLOTS])
                    return 4'((s + i) % bclru_pkg::SLOTS);
        return 4'(s);
    endfunction

    task automatic random_requests(int n);
        int k;
        for (int j = 0; j < n; j++) begin
            if (j % 60 == 0) burst = ($urandom_range(3, 0) == 0);
            k = $urandom_range(99, 0);
            if (k < 45)
                send(bclru_pkg::REQ_GET, pick_block(), pick_bytes(), 4'($urandom),
                     1'($urandom));
            else if (k < 80)
                send(bclru_pkg::REQ_RELEASE, $urandom, 17'($urandom), pick_slot(),
                     1'($urandom));
            else if (k < 95)
                send(bclru_pkg::REQ_FILL, $urandom, 17'($urandom), pick_slot(),
                     1'($urandom));
            else
                send(2'($urandom), $urandom, 17'($urandom), 4'($urandom), 1'($urandom));
        end
        burst = 0;
    endtask

    task automatic test_directed();
        send(bclru_pkg::REQ_GET, 32'd0, 17'd1, 4'd0, 1'b0);              // new slot, smallest size
        send(bclru_pkg::REQ_GET, 32'hFFFF_FFFF, 17'd65536, 4'd15, 1'b1); // new slot, largest values
        send(bclru_pkg::REQ_GET, 32'd0, 17'd1, 4'd0, 1'b0);              // hit, still needs fill
        send(bclru_pkg::REQ_FILL, 32'd0, 17'd0, 4'd0, 1'b0);
        send(bclru_pkg::REQ_GET, 32'd0, 17'd1, 4'd0, 1'b0);              // hit on valid data
        send(bclru_pkg::REQ_GET, 32'd0, 17'd2, 4'd0, 1'b0);              // size mismatch, new slot
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd0, 1'b1);          // still held, dirty
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd0, 1'b0);          // still held
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd0, 1'b1);          // kept idle
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd0, 1'b0);          // idle slot released again
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd15, 1'b1);         // unallocated slot
        send(bclru_pkg::REQ_FILL, 32'd0, 17'd0, 4'd14, 1'b0);            // unallocated slot
        send(bclru_pkg::REQ_NONE, 32'hFFFF_FFFF, 17'h1FFFF, 4'd1, 1'b1); // unknown request type
        set_limit(5'd1);
        send(bclru_pkg::REQ_GET, 32'd7, 17'd1, 4'd0, 1'b0);              // reuse idle slot 0
        send(bclru_pkg::REQ_GET, 32'd8, 17'd512, 4'd0, 1'b0);            // nothing reusable: new
        send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'd3, 1'b1);          // freed over limit
        for (int i = 0; i < 14; i++)                                     // exhaust the pool
            send(bclru_pkg::REQ_GET, 32'(100 + i), 17'd4096, 4'd0, 1'b0);
        send(bclru_pkg::REQ_GET, 32'd999, 17'd4096, 4'd0, 1'b0);         // no slot
        for (int i = 0; i < bclru_pkg::SLOTS; i++)
            send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, 4'(i), i[0]);
        set_limit(5'd10);
    endtask

    // Reference count saturates, then releases go to randomly picked slots.
    task automatic test_refcount_saturate();
        for (int i = 0; i < 260; i++)
            send(bclru_pkg::REQ_GET, 32'h1234_5678, 17'd4096, 4'd0, 1'b0);
        for (int i = 0; i < 260; i++)
            send(bclru_pkg::REQ_RELEASE, 32'd0, 17'd0, pick_slot(), 1'($urandom));
    endtask

    task automatic test_limit_sweep();
        logic [4:0] limits[6] = '{5'd1, 5'd16, 5'd3, 5'd0, 5'd31, 5'd8};
        foreach (limits[i]) begin
            set_limit(limits[i]);
            random_requests(200);
        end
    endtask

    // Hold off the sender until every response is in, then continue.
    task automatic test_pause();
        random_requests(50);
        drain();
        random_requests(50);
    endtask

    initial begin
        lim = bclru_pkg::MAXBUF_RESET;
        nbuf = 5'd0;
        for (int i = 0; i < bclru_pkg::SLOTS; i++) begin
            used[i] = 1'b0; refs[i] = 8'd0; valid[i] = 1'b0; rank[i] = 4'd0;
            blkno[i] = 32'd0; bsize[i] = 17'd0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_refcount_saturate();
        test_limit_sweep();
        test_pause();
        drain();
        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

### filelist.f
rtl/bclru_pkg.sv
rtl/bclru_ctrl.sv
rtl/bclru_dp.sv
rtl/buffer_cache_lru_refcount_top.sv
tb/sv/tb_top.sv
